@@ rtl/core/coverage_gap_finder_defines.svh @@
// Assertion helpers for the coverage gap finder.
// Both macros sample on clk_i and stay quiet while rst_ni is low.
`ifndef COVERAGE_GAP_FINDER_DEFINES_SVH
`define COVERAGE_GAP_FINDER_DEFINES_SVH

// Check a property at every clock edge.
`define CGF_ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a consequence holds in the cycle after its cause.
`define CGF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/cgf_pkg.sv @@
`timescale 1ns / 1ps

package cgf_pkg;

  // Default size of the coverage map, in positions
  localparam int unsigned MaxPositionsDef = 4096;

  // Register reset values
  localparam logic [12:0] SeqLenReset  = 13'd4096;
  localparam logic        ReqMarkReset = 1'b0;

  // Configuration register indexes
  localparam logic [1:0] CFG_SEQ_LEN  = 2'd0;
  localparam logic [1:0] CFG_REQ_MARK = 2'd1;

  // Command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_MARK   = 2'd1;
  localparam logic [1:0] CMD_FETCH  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK_RD,
    ST_MARK,
    ST_FETCH_RD,
    ST_SEEK,
    ST_RUN,
    ST_REPLY
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [12:0] interval_first;
    logic [12:0] interval_last;
  } in_t;

  typedef struct packed {
    logic        gap_found;
    logic [11:0] gap_first;
    logic [11:0] gap_last;
    logic        scan_done;
  } out_t;

endpackage

@@ rtl/core/coverage_gap_finder.sv @@
`timescale 1ns / 1ps
`include "coverage_gap_finder_defines.svh"

// Channel  | Direction | Handshake              | Beat
// ---------+-----------+------------------------+----------------------------
// in       | input     | in_valid_i/in_stall_o  | cgf_pkg::in_t command beat
// out      | output    | out_valid_o/out_stall_i| cgf_pkg::out_t result beat
// cfg      | input     | cfg_valid_i/cfg_ready_o| register index and data
//
// The map is a memory of 64-bit words (8-bit words for maps under 128 positions),
// read through a registered output; mark and fetch walk it one word per cycle.
// Clear writes every word; mark reads and writes back each word it spans; fetch
// reads the words it scans, rereading the word in which a gap starts; a mark
// or fetch that reads no word goes straight to the reply; each result then passes the result stage.
// After reset a clearing pass writes every word (Depth words, 64 by default)
// while input stays stalled; configuration writes are taken at any time.
// A stalled result sits in the output register; the next beat is taken while it waits.
module coverage_gap_finder #(
  parameter int unsigned MaxPositions = cgf_pkg::MaxPositionsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cgf_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cgf_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [12:0]   cfg_data_i
);
  import cgf_pkg::*;

  localparam int unsigned WordW = (MaxPositions >= 128) ? 64 : 8;
  localparam int unsigned OffW  = $clog2(WordW);
  localparam int unsigned IdxW  = $clog2(MaxPositions);
  localparam int unsigned AW    = IdxW - OffW;
  localparam int unsigned Depth = 2 ** AW;
  localparam int unsigned PosW  = IdxW + 1;
  localparam int unsigned CmpW  = (PosW > 13) ? PosW : 13;
  localparam logic [WordW-1:0] Ones = '1;

  // Lowest set bit of a map word
  function automatic logic [OffW-1:0] ffs(input logic [WordW-1:0] v);
    logic [OffW-1:0] idx;
    idx = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (v[i]) idx = OffW'(i);
    end
    return idx;
  endfunction

  state_e            state_q, state_d;
  logic [12:0]       seq_len_q;
  logic              req_mark_q;
  logic [PosW-1:0]   cursor_q, cursor_d;
  logic              any_q, any_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic              reply_q, reply_d;
  logic [AW-1:0]     cur_q, cur_d;
  logic [IdxW-1:0]   lo_q, lo_d;
  logic [IdxW-1:0]   hi_q, hi_d;
  logic [OffW-1:0]   off_q, off_d;
  logic [IdxW-1:0]   start_q, start_d;
  out_t              res_q, res_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_data_q, out_data_d;

  logic [WordW-1:0]  map_mem [Depth];
  logic [WordW-1:0]  rdata_q;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WordW-1:0]  wr_data;

  logic [CmpW-1:0]   len_c, first_c, last_c, mark_first, mark_last;
  logic [PosW-1:0]   len;
  logic              mark_any, fetch_blocked;
  logic [IdxW-1:0]   mark_lo, mark_hi, lenm1, end_pos;
  logic [AW-1:0]     hi_w, last_w;
  logic [OffW-1:0]   last_off;
  logic [WordW-1:0]  mark_mask, in_range, seek_vec, run_vec;
  logic              run_hit;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Clamp the length to the map size
  always_comb begin
    len_c = CmpW'(seq_len_q);
    if (len_c > CmpW'(MaxPositions)) len_c = CmpW'(MaxPositions);
    len      = PosW'(len_c);
    lenm1    = IdxW'(len - PosW'(1));
    last_w   = lenm1[IdxW-1:OffW];
    last_off = lenm1[OffW-1:0];
  end

  // Clamp the incoming interval
  always_comb begin
    first_c    = CmpW'(in_data_i.interval_first);
    last_c     = CmpW'(in_data_i.interval_last);
    mark_first = (first_c == '0) ? CmpW'(1) : first_c;
    mark_last  = (last_c > len_c) ? len_c : last_c;
    mark_any   = (mark_first <= mark_last);
    mark_lo    = IdxW'(mark_first - CmpW'(1));
    mark_hi    = IdxW'(mark_last - CmpW'(1));
  end

  assign fetch_blocked = req_mark_q && !any_q;
  assign hi_w          = hi_q[IdxW-1:OffW];

  // Word masks for mark and scan
  always_comb begin
    mark_mask = Ones;
    if (cur_q == lo_q[IdxW-1:OffW]) mark_mask = mark_mask & (Ones << lo_q[OffW-1:0]);
    if (cur_q == hi_w) mark_mask = mark_mask & (Ones >> ~hi_q[OffW-1:0]);
    in_range = (cur_q == last_w) ? (Ones >> ~last_off) : Ones;
    seek_vec = ~rdata_q & in_range & (Ones << off_q);
    run_vec  = (rdata_q | ~in_range) & (Ones << off_q);
    run_hit  = (|run_vec) || (cur_q == last_w);
    end_pos  = (|run_vec) ? IdxW'({cur_q, ffs(run_vec)} - IdxW'(1)) : lenm1;
  end

  // Next state, memory access and result
  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    any_d       = any_q;
    clr_d       = clr_q;
    reply_d     = reply_q;
    cur_d       = cur_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    off_d       = off_q;
    start_d     = start_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    rd_addr     = cur_q;
    wr_en       = 1'b0;
    wr_addr     = cur_q;
    wr_data     = rdata_q | mark_mask;

    unique case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + AW'(1);
        if (clr_q == AW'(Depth - 1)) state_d = reply_q ? ST_REPLY : ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          res_d = '0;
          if (in_data_i.command == CMD_CLEAR) begin
            cursor_d = '0;
            any_d    = 1'b0;
            clr_d    = '0;
            reply_d  = 1'b1;
            state_d  = ST_CLEAR;
          end else if (in_data_i.command == CMD_MARK) begin
            any_d = 1'b1;
            if (mark_any) begin
              lo_d    = mark_lo;
              hi_d    = mark_hi;
              cur_d   = mark_lo[IdxW-1:OffW];
              state_d = ST_MARK_RD;
            end else begin
              state_d = ST_REPLY;
            end
          end else if (in_data_i.command == CMD_FETCH) begin
            if (fetch_blocked || (cursor_q >= len)) begin
              res_d.scan_done = 1'b1;
              state_d         = ST_REPLY;
            end else begin
              cur_d   = cursor_q[IdxW-1:OffW];
              off_d   = cursor_q[OffW-1:0];
              state_d = ST_FETCH_RD;
            end
          end else begin
            state_d = ST_REPLY;
          end
        end
      end
      ST_MARK_RD: begin
        state_d = ST_MARK;
      end
      ST_MARK: begin
        // Write back the word read last cycle, fetch the next one
        wr_en = 1'b1;
        if (cur_q == hi_w) begin
          state_d = ST_REPLY;
        end else begin
          cur_d   = cur_q + AW'(1);
          rd_addr = cur_q + AW'(1);
        end
      end
      ST_FETCH_RD: begin
        state_d = ST_SEEK;
      end
      ST_SEEK: begin
        if (|seek_vec) begin
          // Reread this word to find where the gap ends
          start_d = {cur_q, ffs(seek_vec)};
          off_d   = ffs(seek_vec);
          state_d = ST_RUN;
        end else if (cur_q == last_w) begin
          res_d.scan_done = 1'b1;
          state_d         = ST_REPLY;
        end else begin
          cur_d   = cur_q + AW'(1);
          rd_addr = cur_q + AW'(1);
          off_d   = '0;
        end
      end
      ST_RUN: begin
        if (run_hit) begin
          res_d.gap_found = 1'b1;
          res_d.gap_first = 12'(start_q);
          res_d.gap_last  = 12'(end_pos);
          cursor_d        = PosW'(end_pos) + PosW'(1);
          state_d         = ST_REPLY;
        end else begin
          cur_d   = cur_q + AW'(1);
          rd_addr = cur_q + AW'(1);
          off_d   = '0;
        end
      end
      ST_REPLY: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      seq_len_q   <= SeqLenReset;
      req_mark_q  <= ReqMarkReset;
      cursor_q    <= '0;
      any_q       <= 1'b0;
      clr_q       <= '0;
      reply_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      any_q       <= any_d;
      clr_q       <= clr_d;
      reply_q     <= reply_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_SEQ_LEN) seq_len_q <= cfg_data_i;
        else if (cfg_index_i == CFG_REQ_MARK) req_mark_q <= cfg_data_i[0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    off_q      <= off_d;
    start_q    <= start_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  // Coverage map memory
  always_ff @(posedge clk_i) begin
    if (wr_en) map_mem[wr_addr] <= wr_data;
    rdata_q <= map_mem[rd_addr];
  end

  `CGF_ASSERT_HOLDS(a_scan_no_write, (state_q == ST_SEEK || state_q == ST_RUN) |-> !wr_en, "map written during scan")
  `CGF_ASSERT_HOLDS(a_mark_in_bounds, (state_q == ST_MARK) |-> (cur_q <= hi_w), "mark walked past interval")
  `CGF_ASSERT_NEXT(a_mark_ends, state_q == ST_MARK && cur_q == hi_w, state_q == ST_REPLY, "mark did not finish")
  `CGF_ASSERT_HOLDS(a_gap_order, (state_q == ST_RUN && run_hit) |-> (end_pos >= start_q), "gap ends before start")
  `CGF_ASSERT_HOLDS(a_clear_state, (state_q == ST_CLEAR && reply_q) |-> (cursor_q == '0 && !any_q), "clear left scan state")
  `CGF_ASSERT_HOLDS(a_result_kind, out_valid_o |-> !(out_data_o.gap_found && out_data_o.scan_done), "gap and done together")

endmodule

@@ sim/coverage_gap_finder_tb.sv @@
`timescale 1ns / 1ps

module coverage_gap_finder_tb;
  import cgf_pkg::*;

  localparam int unsigned MapSize = MaxPositionsDef;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_SEQ_LEN;
  logic [12:0] cfg_data = '0;

  // Shadow of the block: coverage map, scan cursor, mark flag and registers
  bit [MapSize-1:0] cov_map;
  int unsigned      scan_pos;
  bit               marked_any;
  bit [12:0]        seq_len = SeqLenReset;
  bit               need_mark = ReqMarkReset;

  out_t        expected_gaps[$];
  int unsigned errors = 0;
  bit          idle_on = 1'b1;
  int unsigned stim_len = SeqLenReset;

  coverage_gap_finder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one command beat to the shadow state and return its reply
  function automatic out_t predict_reply(in_t beat);
    out_t        r;
    int unsigned span;
    int unsigned lo;
    int unsigned hi;
    int unsigned p;
    r = '0;
    span = (seq_len > MapSize) ? MapSize : seq_len;
    case (beat.command)
      CMD_CLEAR: begin
        cov_map = '0;
        scan_pos = 0;
        marked_any = 1'b0;
      end
      CMD_MARK: begin
        marked_any = 1'b1;
        lo = beat.interval_first;
        hi = beat.interval_last;
        if (lo < 1) lo = 1;
        if (hi > span) hi = span;
        for (p = lo; p <= hi; p++) cov_map[p-1] = 1'b1;
      end
      CMD_FETCH: begin
        if (!(need_mark && !marked_any)) begin
          p = scan_pos;
          while (p < span && cov_map[p]) p++;
          if (p < span) begin
            r.gap_found = 1'b1;
            r.gap_first = p[11:0];
            while (p + 1 < span && !cov_map[p+1]) p++;
            r.gap_last = p[11:0];
            scan_pos = p + 1;
          end
        end
        if (!r.gap_found) r.scan_done = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // Watch all three channels: compare replies, predict commands, track registers
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_gaps.size() == 0) begin
          errors++;
          $display("%0t unexpected reply: expected none actual %h", $time, out_data);
        end else begin
          want = expected_gaps.pop_front();
          check_field("gap_found", 12'(want.gap_found), 12'(out_data.gap_found));
          check_field("gap_first", want.gap_first, out_data.gap_first);
          check_field("gap_last", want.gap_last, out_data.gap_last);
          check_field("scan_done", 12'(want.scan_done), 12'(out_data.scan_done));
        end
      end
      if (in_valid && !in_stall)
        expected_gaps.insert(expected_gaps.size(), predict_reply(in_data));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SEQ_LEN) seq_len = cfg_data;
        else if (cfg_index == CFG_REQ_MARK) need_mark = cfg_data[0];
      end
    end
  end

  // Random backpressure on the reply side
  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 22);
  end

  function automatic in_t make_beat(logic [1:0] cmd, int unsigned first, int unsigned last);
    in_t b;
    b.command = cmd;
    b.interval_first = 13'(first);
    b.interval_last = 13'(last);
    return b;
  endfunction

  // Send one command beat; valid stays high afterwards for a back-to-back beat
  task automatic send_beat(in_t beat);
    if (idle_on) begin
      while ($urandom_range(99) < 22) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every reply is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_gaps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers while the block is idle
  task automatic set_config(int unsigned len, bit req);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SEQ_LEN;
    cfg_data <= 13'(len);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_REQ_MARK;
    cfg_data <= {12'd0, req};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    stim_len = len;
  endtask

  task automatic test_defaults();
    send_beat(make_beat(CMD_FETCH, 0, 0));
    send_beat(make_beat(CMD_FETCH, 8191, 8191));
    send_beat(make_beat(CMD_UNUSED, 8191, 0));
  endtask

  // Clamp at both ends, empty interval, single and adjacent marks
  task automatic test_clamping();
    set_config(20, 1'b0);
    send_beat(make_beat(CMD_CLEAR, 0, 0));
    send_beat(make_beat(CMD_MARK, 0, 3));
    send_beat(make_beat(CMD_MARK, 18, 9000));
    send_beat(make_beat(CMD_MARK, 8, 6));
    send_beat(make_beat(CMD_MARK, 8191, 8191));
    send_beat(make_beat(CMD_MARK, 10, 10));
    send_beat(make_beat(CMD_MARK, 11, 12));
    send_beat(make_beat(CMD_FETCH, 0, 0));
    send_beat(make_beat(CMD_FETCH, 0, 0));
    send_beat(make_beat(CMD_FETCH, 0, 0));
  endtask

  // No gap until a mark arrives, even one that covers nothing
  task automatic test_require_mark();
    set_config(20, 1'b1);
    send_beat(make_beat(CMD_CLEAR, 0, 0));
    send_beat(make_beat(CMD_FETCH, 0, 0));
    send_beat(make_beat(CMD_MARK, 5, 3));
    send_beat(make_beat(CMD_FETCH, 0, 0));
    send_beat(make_beat(CMD_FETCH, 0, 0));
  endtask

  // Empty sequence, saturated length and a single position
  task automatic test_length_extremes();
    set_config(0, 1'b0);
    send_beat(make_beat(CMD_CLEAR, 0, 0));
    send_beat(make_beat(CMD_MARK, 1, 1));
    send_beat(make_beat(CMD_FETCH, 0, 0));
    set_config(8191, 1'b0);
    send_beat(make_beat(CMD_FETCH, 0, 0));
    set_config(1, 1'b0);
    send_beat(make_beat(CMD_CLEAR, 0, 0));
    send_beat(make_beat(CMD_FETCH, 0, 0));
  endtask

  // Mostly clear / marks / fetches sequences with random content, some noise
  task automatic run_phase(int unsigned n_items);
    int unsigned sent;
    int unsigned span;
    int unsigned n_marks;
    int unsigned lo;
    int unsigned w;
    in_t         b;
    sent = 0;
    span = (stim_len > MapSize) ? MapSize : stim_len;
    while (sent < n_items) begin
      if ($urandom_range(9) < 8) begin
        if ($urandom_range(3) != 0) begin
          send_beat(make_beat(CMD_CLEAR, $urandom, $urandom));
          sent++;
        end
        n_marks = $urandom_range(0, 6);
        repeat (n_marks) begin
          if ($urandom_range(9) == 0) begin
            b = make_beat(CMD_MARK, $urandom, $urandom);
          end else begin
            lo = $urandom_range(0, span + 1);
            w = $urandom_range(0, span / 6 + 1);
            if ($urandom_range(7) == 0) b = make_beat(CMD_MARK, lo + w + 1, lo);
            else b = make_beat(CMD_MARK, lo, lo + w);
          end
          send_beat(b);
          sent++;
        end
        repeat (n_marks + $urandom_range(1, 3)) begin
          send_beat(make_beat(CMD_FETCH, $urandom, $urandom));
          sent++;
        end
      end else begin
        send_beat(make_beat(2'($urandom), $urandom, $urandom));
        sent++;
      end
    end
  endtask

  task automatic test_random();
    int unsigned lens[8];
    lens = '{64, 1, 4096, 130, 8191, 0, 17, 4097};
    lens[7] = $urandom_range(1, 4096);
    foreach (lens[i]) begin
      set_config(lens[i], 1'($urandom));
      idle_on = (i != 2);
      run_phase(128);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_clamping();
    test_require_mark();
    test_length_extremes();
    test_random();
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
